FILE: src/pts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_pkg
// shared types, codes and sizes of the priority task scheduler
// ----------------------------------------------------------------------------
package pts_pkg;

    localparam int PTS_MAX_TASKS = 16;
    localparam int PTS_NUM_PRIO  = 8;

    localparam int TICK_RATE_W = 20;
    localparam int PRIO_W      = 8;
    localparam int DELAY_W     = 32;
    localparam int STATUS_W    = 3;
    localparam int ID_W        = 4;
    localparam int TICK_W      = 64;

    localparam logic [TICK_RATE_W-1:0] TICK_RATE_RST = 20'd1000;

    // ms * rate + 999 and its quotient by 1000, one 16 bit chunk per cycle
    localparam int PROD_W    = DELAY_W + TICK_RATE_W;
    localparam int NUM_W     = 64;
    localparam int CHUNK_W   = 16;
    localparam int DIV_STEPS = NUM_W / CHUNK_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int REM_W     = 10;
    localparam int PART_W    = REM_W + CHUNK_W;
    localparam int RECIP_W   = 27;
    localparam int RECIP_SH  = 36;
    localparam int MULQ_W    = PART_W + RECIP_W;

    localparam logic [NUM_W-1:0]   ROUND_UP = NUM_W'(999);
    localparam logic [REM_W-1:0]   DIVISOR  = 10'd1000;
    // ceil(2^36 / 1000), exact for every partial dividend below 1000 * 2^16
    localparam logic [RECIP_W-1:0] RECIP    = 27'd68719477;

    // commands
    localparam logic [1:0] CMD_CREATE   = 2'd0;
    localparam logic [1:0] CMD_TICK     = 2'd1;
    localparam logic [1:0] CMD_SCHEDULE = 2'd2;
    localparam logic [1:0] CMD_DELAY    = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] RES_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] RES_BAD_PRIO = 3'd1;
    localparam logic [STATUS_W-1:0] RES_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] RES_IDLE     = 3'd3;
    localparam logic [STATUS_W-1:0] RES_NO_CUR   = 3'd4;

    typedef enum logic [1:0] {
        TS_UNUSED  = 2'd0,
        TS_READY   = 2'd1,
        TS_RUNNING = 2'd2,
        TS_DELAYED = 2'd3
    } t_task_st;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APP0,
        S_APP1,
        S_TK_RD,
        S_TK_CHK,
        S_SC_POP,
        S_DL_DIV,
        S_DL_WAKE,
        S_DL_HEAD,
        S_DL_WALK,
        S_DL_CMP,
        S_DL_LNK1,
        S_DL_LNK2,
        S_FIN
    } t_state;

endpackage

FILE: src/pts_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_if
// command and result channels of the priority task scheduler
// ----------------------------------------------------------------------------
interface pts_cmd_if
    import pts_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [1:0]           cmd;
    logic [PRIO_W-1:0]    priority_req;
    logic [DELAY_W-1:0]   delay_ms;

    modport source (output valid, cmd, priority_req, delay_ms, input ready);
    modport sink   (input valid, cmd, priority_req, delay_ms, output ready);
endinterface

interface pts_res_if
    import pts_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic [ID_W-1:0]      task_id;
    logic                 task_valid;
    logic [ID_W-1:0]      running_task;
    logic                 running_valid;
    logic                 resched_pending;
    logic [TICK_W-1:0]    tick_now;

    modport source (output valid, status, task_id, task_valid, running_task,
                    running_valid, resched_pending, tick_now, input ready);
    modport sink   (input valid, status, task_id, task_valid, running_task,
                    running_valid, resched_pending, tick_now, output ready);
endinterface

FILE: src/priority_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_scheduler
// fixed priority round robin scheduler over a table of task slots
// ----------------------------------------------------------------------------
// One command is worked on at a time; a new one is taken once the previous
// result sits in the output register. Task links and wake ticks live in two
// synchronous memories with one write and one read port each, so every list
// step waits on a registered read. Delay turns milliseconds into ticks as
// ms * rate / 1000 rounded up, dividing by 1000 16 bits per cycle by
// reciprocal multiplication. A stalled result holds the next one in S_FIN.
// The tick rate register may only be written while no command is in flight.
// ----------------------------------------------------------------------------
module priority_task_scheduler
    import pts_pkg::*;
#(
    parameter int MAX_TASKS      = PTS_MAX_TASKS,
    parameter int NUM_PRIORITIES = PTS_NUM_PRIO
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_wr_en,
    input  logic [TICK_RATE_W-1:0]  i_cfg_wr_data,
    pts_cmd_if.sink                 i_cmd,
    pts_res_if.source               o_res
);

    localparam int SW = $clog2(MAX_TASKS);
    localparam int PW = SW + 1;                 // slot pointer with a nil code
    localparam int QW = $clog2(NUM_PRIORITIES);
    localparam logic [PW-1:0] NIL = PW'(MAX_TASKS);

    // control state
    t_state                 r_state, n_state;
    logic [TICK_RATE_W-1:0] r_tick_rate;
    t_task_st               r_tstat [MAX_TASKS];
    t_task_st               n_tstat [MAX_TASKS];
    logic [PW-1:0]          r_head [NUM_PRIORITIES];
    logic [PW-1:0]          n_head [NUM_PRIORITIES];
    logic [PW-1:0]          r_dhead, n_dhead;
    logic [PW-1:0]          r_cur, n_cur;
    logic [TICK_W-1:0]      r_tick, n_tick;
    logic                   r_resched, n_resched;
    logic                   r_ov, n_ov;

    // working registers
    logic [QW-1:0]          r_prio [MAX_TASKS];
    logic [QW-1:0]          n_prio [MAX_TASKS];
    logic [PW-1:0]          r_tail [NUM_PRIORITIES];
    logic [PW-1:0]          n_tail [NUM_PRIORITIES];
    logic [PW-1:0]          r_slot, n_slot;
    logic [PW-1:0]          r_ap_slot, n_ap_slot;
    logic [QW-1:0]          r_ap_prio, n_ap_prio;
    t_state                 r_ret, n_ret;
    logic [QW-1:0]          r_pq, n_pq;
    logic [NUM_W-1:0]       r_num, n_num;
    logic [REM_W-1:0]       r_rem, n_rem;
    logic [DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [TICK_W-1:0]      r_wake, n_wake;
    logic [PW-1:0]          r_wcur, n_wcur;
    logic [PW-1:0]          r_wnxt, n_wnxt;
    logic [STATUS_W-1:0]    r_rstat, n_rstat;
    logic [PW-1:0]          r_id, n_id;
    logic                   r_idv, n_idv;

    // result register
    logic [STATUS_W-1:0]    r_o_status;
    logic [ID_W-1:0]        r_o_id;
    logic                   r_o_idv;
    logic [ID_W-1:0]        r_o_run;
    logic                   r_o_runv;
    logic                   r_o_resched;
    logic [TICK_W-1:0]      r_o_tick;
    logic                   load_out;

    // link and wake memories
    logic [PW-1:0]          m_link [MAX_TASKS];
    logic [TICK_W-1:0]      m_wake [MAX_TASKS];
    logic [PW-1:0]          r_link_q;
    logic [TICK_W-1:0]      r_wake_q;
    logic                   link_we, wake_we, rd_en;
    logic [SW-1:0]          link_wa, wake_wa, rd_a;
    logic [PW-1:0]          link_wd;
    logic [TICK_W-1:0]      wake_wd;

    // searches and arithmetic
    logic [PW-1:0]          free_slot;
    logic                   free_ok;
    logic [QW-1:0]          top_prio;
    logic                   top_ok;
    logic                   cmd_xfer;
    logic [PROD_W-1:0]      prod;
    logic [PART_W-1:0]      div_part;
    logic [MULQ_W-1:0]      div_prod;
    logic [CHUNK_W-1:0]     div_q;
    logic [REM_W-1:0]       div_r;
    logic [TICK_W-1:0]      ticks;
    logic [TICK_W-1:0]      wake_new;

    assign cmd_xfer    = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = (r_state == S_IDLE);

    // lowest free slot
    always_comb begin
        free_slot = NIL;
        free_ok   = 1'b0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (r_tstat[i] == TS_UNUSED) begin
                free_slot = PW'(i);
                free_ok   = 1'b1;
            end
        end
    end

    // highest non-empty ready queue
    always_comb begin
        top_prio = '0;
        top_ok   = 1'b0;
        for (int p = 0; p < NUM_PRIORITIES; p++) begin
            if (r_head[p] != NIL) begin
                top_prio = QW'(p);
                top_ok   = 1'b1;
            end
        end
    end

    // 32 x 20 product, then long division by 1000 a 16 bit chunk per cycle:
    // each partial dividend is divided by a reciprocal multiply
    assign prod     = PROD_W'(i_cmd.delay_ms) * PROD_W'(r_tick_rate);
    assign div_part = {r_rem, r_num[NUM_W-1 -: CHUNK_W]};
    assign div_prod = MULQ_W'(div_part) * MULQ_W'(RECIP);
    assign div_q    = div_prod[RECIP_SH +: CHUNK_W];
    assign div_r    = REM_W'(div_part - PART_W'(div_q) * PART_W'(DIVISOR));
    assign ticks    = (r_num == '0) ? TICK_W'(1) : TICK_W'(r_num);
    assign wake_new = r_tick + ticks;

    always_comb begin
        n_state   = r_state;
        n_tstat   = r_tstat;
        n_head    = r_head;
        n_dhead   = r_dhead;
        n_cur     = r_cur;
        n_tick    = r_tick;
        n_resched = r_resched;
        n_prio    = r_prio;
        n_tail    = r_tail;
        n_slot    = r_slot;
        n_ap_slot = r_ap_slot;
        n_ap_prio = r_ap_prio;
        n_ret     = r_ret;
        n_pq      = r_pq;
        n_num     = r_num;
        n_rem     = r_rem;
        n_cnt     = r_cnt;
        n_wake    = r_wake;
        n_wcur    = r_wcur;
        n_wnxt    = r_wnxt;
        n_rstat   = r_rstat;
        n_id      = r_id;
        n_idv     = r_idv;
        link_we   = 1'b0;
        link_wa   = r_slot[SW-1:0];
        link_wd   = NIL;
        wake_we   = 1'b0;
        wake_wa   = r_slot[SW-1:0];
        wake_wd   = wake_new;
        rd_en     = 1'b0;
        rd_a      = r_dhead[SW-1:0];
        load_out  = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (cmd_xfer) begin
                    n_rstat = RES_OK;
                    n_id    = '0;
                    n_idv   = 1'b0;
                    n_state = S_FIN;
                    unique case (i_cmd.cmd)
                        CMD_CREATE: begin
                            if (32'(i_cmd.priority_req) >= 32'(NUM_PRIORITIES)) begin
                                n_rstat = RES_BAD_PRIO;
                            end else if (!free_ok) begin
                                n_rstat = RES_FULL;
                            end else begin
                                n_tstat[free_slot[SW-1:0]] = TS_READY;
                                n_prio[free_slot[SW-1:0]]  = QW'(i_cmd.priority_req);
                                n_id      = free_slot;
                                n_idv     = 1'b1;
                                n_ap_slot = free_slot;
                                n_ap_prio = QW'(i_cmd.priority_req);
                                n_ret     = S_FIN;
                                n_state   = S_APP0;
                            end
                        end
                        CMD_TICK: begin
                            n_tick    = r_tick + TICK_W'(1);
                            n_resched = 1'b1;
                            n_state   = S_TK_RD;
                        end
                        CMD_SCHEDULE: begin
                            if (!top_ok) begin
                                n_rstat = RES_IDLE;
                            end else begin
                                n_pq    = top_prio;
                                n_slot  = r_head[top_prio];
                                rd_en   = 1'b1;
                                rd_a    = r_head[top_prio][SW-1:0];
                                n_state = S_SC_POP;
                            end
                        end
                        CMD_DELAY: begin
                            if (r_cur == NIL) begin
                                n_rstat = RES_NO_CUR;
                            end else begin
                                n_slot  = r_cur;
                                n_num   = NUM_W'(prod) + ROUND_UP;
                                n_rem   = '0;
                                n_cnt   = '0;
                                n_state = S_DL_DIV;
                            end
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end

            // append r_ap_slot to the tail of its ready queue
            S_APP0: begin
                link_we = 1'b1;
                link_wa = r_ap_slot[SW-1:0];
                link_wd = NIL;
                if (r_head[r_ap_prio] == NIL) begin
                    n_head[r_ap_prio] = r_ap_slot;
                    n_tail[r_ap_prio] = r_ap_slot;
                    n_state           = r_ret;
                end else begin
                    n_state = S_APP1;
                end
            end
            S_APP1: begin
                link_we           = 1'b1;
                link_wa           = r_tail[r_ap_prio][SW-1:0];
                link_wd           = r_ap_slot;
                n_tail[r_ap_prio] = r_ap_slot;
                n_state           = r_ret;
            end

            // wake every due task at the front of the delayed list
            S_TK_RD: begin
                if (r_dhead == NIL) begin
                    n_state = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_a    = r_dhead[SW-1:0];
                    n_slot  = r_dhead;
                    n_state = S_TK_CHK;
                end
            end
            S_TK_CHK: begin
                if (r_wake_q <= r_tick) begin
                    n_dhead                 = r_link_q;
                    n_tstat[r_slot[SW-1:0]] = TS_READY;
                    n_ap_slot               = r_slot;
                    n_ap_prio               = r_prio[r_slot[SW-1:0]];
                    n_ret                   = S_TK_RD;
                    n_state                 = S_APP0;
                end else begin
                    n_state = S_FIN;
                end
            end

            // pop the chosen head, requeue the task that ran before
            S_SC_POP: begin
                n_head[r_pq]            = r_link_q;
                link_we                 = 1'b1;
                link_wa                 = r_slot[SW-1:0];
                link_wd                 = NIL;
                n_cur                   = r_slot;
                n_tstat[r_slot[SW-1:0]] = TS_RUNNING;
                n_resched               = 1'b0;
                n_id                    = r_slot;
                n_idv                   = 1'b1;
                n_state                 = S_FIN;
                if (r_cur != NIL && r_cur != r_slot
                    && r_tstat[r_cur[SW-1:0]] == TS_RUNNING) begin
                    n_tstat[r_cur[SW-1:0]] = TS_READY;
                    n_ap_slot              = r_cur;
                    n_ap_prio              = r_prio[r_cur[SW-1:0]];
                    n_ret                  = S_FIN;
                    n_state                = S_APP0;
                end
            end

            // ceil(ms * rate / 1000), quotient chunks shift into r_num
            S_DL_DIV: begin
                n_rem = div_r;
                n_num = {r_num[NUM_W-CHUNK_W-1:0], div_q};
                n_cnt = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DL_WAKE;
                end
            end
            S_DL_WAKE: begin
                n_wake                  = wake_new;
                wake_we                 = 1'b1;
                n_tstat[r_slot[SW-1:0]] = TS_DELAYED;
                n_cur                   = NIL;
                n_resched               = 1'b0;
                if (r_dhead == NIL) begin
                    link_we = 1'b1;
                    link_wd = NIL;
                    n_dhead = r_slot;
                    n_state = S_FIN;
                end else begin
                    rd_en   = 1'b1;
                    rd_a    = r_dhead[SW-1:0];
                    n_state = S_DL_HEAD;
                end
            end
            S_DL_HEAD: begin
                if (r_wake < r_wake_q) begin
                    link_we = 1'b1;
                    link_wd = r_dhead;
                    n_dhead = r_slot;
                    n_state = S_FIN;
                end else begin
                    n_wcur  = r_dhead;
                    n_wnxt  = r_link_q;
                    n_state = S_DL_WALK;
                end
            end
            S_DL_WALK: begin
                if (r_wnxt == NIL) begin
                    n_state = S_DL_LNK1;
                end else begin
                    rd_en   = 1'b1;
                    rd_a    = r_wnxt[SW-1:0];
                    n_state = S_DL_CMP;
                end
            end
            S_DL_CMP: begin
                // equal wake ticks go behind, keeping delay order
                if (r_wake_q <= r_wake) begin
                    n_wcur  = r_wnxt;
                    n_wnxt  = r_link_q;
                    n_state = S_DL_WALK;
                end else begin
                    n_state = S_DL_LNK1;
                end
            end
            S_DL_LNK1: begin
                link_we = 1'b1;
                link_wd = r_wnxt;
                n_state = S_DL_LNK2;
            end
            S_DL_LNK2: begin
                link_we = 1'b1;
                link_wa = r_wcur[SW-1:0];
                link_wd = r_slot;
                n_state = S_FIN;
            end

            // hand the result to the output register
            S_FIN: begin
                if (!r_ov || o_res.ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        if (load_out) begin
            n_ov = 1'b1;
        end else if (r_ov && o_res.ready) begin
            n_ov = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tick_rate <= TICK_RATE_RST;
            r_dhead     <= NIL;
            r_cur       <= NIL;
            r_tick      <= '0;
            r_resched   <= 1'b0;
            r_ov        <= 1'b0;
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_tstat[i] <= TS_UNUSED;
            end
            for (int p = 0; p < NUM_PRIORITIES; p++) begin
                r_head[p] <= NIL;
            end
        end else begin
            r_state   <= n_state;
            r_dhead   <= n_dhead;
            r_cur     <= n_cur;
            r_tick    <= n_tick;
            r_resched <= n_resched;
            r_ov      <= n_ov;
            r_tstat   <= n_tstat;
            r_head    <= n_head;
            if (i_cfg_wr_en) begin
                r_tick_rate <= i_cfg_wr_data;
            end
        end
    end

    // working and result registers
    always_ff @(posedge i_clk) begin
        r_prio    <= n_prio;
        r_tail    <= n_tail;
        r_slot    <= n_slot;
        r_ap_slot <= n_ap_slot;
        r_ap_prio <= n_ap_prio;
        r_ret     <= n_ret;
        r_pq      <= n_pq;
        r_num     <= n_num;
        r_rem     <= n_rem;
        r_cnt     <= n_cnt;
        r_wake    <= n_wake;
        r_wcur    <= n_wcur;
        r_wnxt    <= n_wnxt;
        r_rstat   <= n_rstat;
        r_id      <= n_id;
        r_idv     <= n_idv;
        if (load_out) begin
            r_o_status  <= r_rstat;
            r_o_id      <= r_idv ? ID_W'(r_id) : '0;
            r_o_idv     <= r_idv;
            r_o_run     <= (r_cur != NIL) ? ID_W'(r_cur) : '0;
            r_o_runv    <= (r_cur != NIL);
            r_o_resched <= r_resched;
            r_o_tick    <= r_tick;
        end
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (link_we) begin
            m_link[link_wa] <= link_wd;
        end
        if (rd_en) begin
            r_link_q <= m_link[rd_a];
        end
    end

    // wake tick memory
    always_ff @(posedge i_clk) begin
        if (wake_we) begin
            m_wake[wake_wa] <= wake_wd;
        end
        if (rd_en) begin
            r_wake_q <= m_wake[rd_a];
        end
    end

    assign o_res.valid           = r_ov;
    assign o_res.status          = r_o_status;
    assign o_res.task_id         = r_o_id;
    assign o_res.task_valid      = r_o_idv;
    assign o_res.running_task    = r_o_run;
    assign o_res.running_valid   = r_o_runv;
    assign o_res.resched_pending = r_o_resched;
    assign o_res.tick_now        = r_o_tick;

endmodule

FILE: src/pts_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_checker
// port level checks on the result channel of the scheduler
// ----------------------------------------------------------------------------
module pts_checker
    import pts_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                i_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [ID_W-1:0]     i_task_id,
    input logic                i_task_valid,
    input logic [ID_W-1:0]     i_running_task,
    input logic                i_running_valid
);

    // stalled result keeps its valid, status and task id
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_task_id))
        else $error("result changed while stalled");

    a_id_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_task_valid || i_task_id == '0))
        else $error("task id without slot not zero");

    a_run_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (i_running_valid || i_running_task == '0))
        else $error("running task without slot not zero");

    // errors never carry a slot
    a_err_noslot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status != RES_OK |-> !i_task_valid)
        else $error("error result carries a slot");

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_status        (o_res.status),
    .i_task_id       (o_res.task_id),
    .i_task_valid    (o_res.task_valid),
    .i_running_task  (o_res.running_task),
    .i_running_valid (o_res.running_valid)
);

FILE: test/pts_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pts_scoreboard
// behavioural scheduler and queue of expected results
// ----------------------------------------------------------------------------
// Mirrors the task table, ready fifos and delayed list of the scheduler. Each
// accepted command is stepped through the mirror and the result is queued.
// Returned results are compared in order against that queue.
// ----------------------------------------------------------------------------
import pts_pkg::*;

typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     task_id;
    logic                task_valid;
    logic [ID_W-1:0]     running_task;
    logic                running_valid;
    logic                resched_pending;
    logic [TICK_W-1:0]   tick_now;
} t_sched_res;

class pts_scoreboard;
    localparam int NT  = PTS_MAX_TASKS;
    localparam int NP  = PTS_NUM_PRIO;
    localparam int NIL = NT;

    t_task_st          slot_st [NT];
    int                slot_prio [NT];
    logic [TICK_W-1:0] slot_wake [NT];
    int                slot_link [NT];
    int                fifo_head [NP];
    int                sleep_head;
    int                cur_slot;
    logic [TICK_W-1:0] ticks;
    bit                resched;
    logic [TICK_RATE_W-1:0] rate;
    t_sched_res        pending [$];
    int                errors;

    function new();
        foreach (slot_st[i]) begin
            slot_st[i] = TS_UNUSED;
            slot_prio[i] = 0;
            slot_wake[i] = '0;
            slot_link[i] = 0;
        end
        foreach (fifo_head[i]) fifo_head[i] = NIL;
        sleep_head = NIL;
        cur_slot = NIL;
        ticks = '0;
        resched = 1'b0;
        rate = TICK_RATE_RST;
        errors = 0;
    endfunction

    function void set_rate(logic [TICK_RATE_W-1:0] r);
        rate = r;
    endfunction

    function void fifo_push(int s);
        int p;
        int c;
        p = slot_prio[s];
        slot_link[s] = NIL;
        if (fifo_head[p] == NIL) begin
            fifo_head[p] = s;
        end else begin
            c = fifo_head[p];
            while (slot_link[c] != NIL) c = slot_link[c];
            slot_link[c] = s;
        end
    endfunction

    function void sleep_insert(int s);
        int c;
        if (sleep_head == NIL || slot_wake[s] < slot_wake[sleep_head]) begin
            slot_link[s] = sleep_head;
            sleep_head = s;
        end else begin
            c = sleep_head;
            while (slot_link[c] != NIL && slot_wake[slot_link[c]] <= slot_wake[s])
                c = slot_link[c];
            slot_link[s] = slot_link[c];
            slot_link[c] = s;
        end
    endfunction

    // step the mirror on one accepted command
    function void note_command(logic [1:0] cmd, logic [PRIO_W-1:0] prio,
                               logic [DELAY_W-1:0] ms);
        t_sched_res r;
        int slot;
        int prev;
        logic [63:0] dly;
        r = '0;
        case (cmd)
            CMD_CREATE: begin
                if (32'(prio) >= NP) begin
                    r.status = RES_BAD_PRIO;
                end else begin
                    slot = NIL;
                    for (int i = NT - 1; i >= 0; i--)
                        if (slot_st[i] == TS_UNUSED) slot = i;
                    if (slot == NIL) begin
                        r.status = RES_FULL;
                    end else begin
                        slot_prio[slot] = 32'(prio);
                        slot_st[slot] = TS_READY;
                        fifo_push(slot);
                        r.task_id = slot[ID_W-1:0];
                        r.task_valid = 1'b1;
                    end
                end
            end
            CMD_TICK: begin
                ticks = ticks + 64'd1;
                while (sleep_head != NIL && slot_wake[sleep_head] <= ticks) begin
                    slot = sleep_head;
                    sleep_head = slot_link[slot];
                    slot_st[slot] = TS_READY;
                    fifo_push(slot);
                end
                resched = 1'b1;
            end
            CMD_SCHEDULE: begin
                slot = NIL;
                for (int p = NP - 1; p >= 0 && slot == NIL; p--)
                    if (fifo_head[p] != NIL) begin
                        slot = fifo_head[p];
                        fifo_head[p] = slot_link[slot];
                        slot_link[slot] = NIL;
                    end
                if (slot == NIL) begin
                    r.status = RES_IDLE;
                end else begin
                    prev = cur_slot;
                    cur_slot = slot;
                    slot_st[slot] = TS_RUNNING;
                    if (prev != NIL && prev != slot && slot_st[prev] == TS_RUNNING) begin
                        slot_st[prev] = TS_READY;
                        fifo_push(prev);
                    end
                    resched = 1'b0;
                    r.task_id = slot[ID_W-1:0];
                    r.task_valid = 1'b1;
                end
            end
            default: begin
                if (cur_slot == NIL) begin
                    r.status = RES_NO_CUR;
                end else begin
                    dly = (64'(ms) * 64'(rate) + 64'd999) / 64'd1000;
                    if (dly == 64'd0) dly = 64'd1;
                    slot_wake[cur_slot] = ticks + dly;
                    slot_st[cur_slot] = TS_DELAYED;
                    sleep_insert(cur_slot);
                    cur_slot = NIL;
                    resched = 1'b0;
                end
            end
        endcase
        if (cur_slot != NIL) begin
            r.running_task = cur_slot[ID_W-1:0];
            r.running_valid = 1'b1;
        end
        r.resched_pending = resched;
        r.tick_now = ticks;
        pending.push_back(r);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    task check_result(t_sched_res got);
        t_sched_res w;
        if (pending.size() == 0) begin
            report("unexpected result", 64'(got.status), 64'(0));
            return;
        end
        w = pending.pop_front();
        if (got.status !== w.status)
            report("status", 64'(got.status), 64'(w.status));
        if (got.task_id !== w.task_id)
            report("task_id", 64'(got.task_id), 64'(w.task_id));
        if (got.task_valid !== w.task_valid)
            report("task_valid", 64'(got.task_valid), 64'(w.task_valid));
        if (got.running_task !== w.running_task)
            report("running_task", 64'(got.running_task), 64'(w.running_task));
        if (got.running_valid !== w.running_valid)
            report("running_valid", 64'(got.running_valid), 64'(w.running_valid));
        if (got.resched_pending !== w.resched_pending)
            report("resched_pending", 64'(got.resched_pending),
                   64'(w.resched_pending));
        if (got.tick_now !== w.tick_now) report("tick_now", got.tick_now, w.tick_now);
    endtask
endclass

FILE: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and checking of the priority task scheduler
// ----------------------------------------------------------------------------
// Drives directed and random command transfers in bursts with gaps while the
// result side stalls on its own pattern; every result is compared with the
// scoreboard mirror. The tick rate is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module testbench;
    import pts_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_wr_en;
    logic [TICK_RATE_W-1:0] i_cfg_wr_data;

    pts_cmd_if cmd_ch ();
    pts_res_if res_ch ();

    priority_task_scheduler DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_cmd         (cmd_ch.sink),
        .o_res         (res_ch.source)
    );

    pts_scoreboard sched_mirror;
    int idle_cycles = 0;
    int burst_left;
    bit stall_on = 1'b0;

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // result side: compare every transfer, watchdog on no progress
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_ch.valid && res_ch.ready) begin
                sched_mirror.check_result({res_ch.status, res_ch.task_id,
                    res_ch.task_valid, res_ch.running_task, res_ch.running_valid,
                    res_ch.resched_pending, res_ch.tick_now});
            end
            if ((res_ch.valid && res_ch.ready) || (cmd_ch.valid && cmd_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // receiver stall pattern: long open stretches, then choppy phases
    always @(negedge i_clk) begin
        if (($urandom_range(0, 63)) == 0) stall_on <= ~stall_on;
        res_ch.ready <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b1;
    end

    // one command transfer, with burst and gap shaping
    task automatic send_cmd(logic [1:0] c, logic [PRIO_W-1:0] p, logic [DELAY_W-1:0] m);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                cmd_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        cmd_ch.valid <= 1'b1;
        cmd_ch.cmd <= c;
        cmd_ch.priority_req <= p;
        cmd_ch.delay_ms <= m;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sched_mirror.note_command(c, p, m);
        @(negedge i_clk);
    endtask

    // wait until every outstanding result has come back
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (sched_mirror.pending.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    // tick rate write while idle
    task automatic write_rate(logic [TICK_RATE_W-1:0] r);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= r;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sched_mirror.set_rate(r);
    endtask

    // mostly short delays so tasks come back to life, the odd huge one
    function automatic logic [DELAY_W-1:0] pick_ms();
        case ($urandom_range(0, 9))
            0: return $urandom();
            1: return 32'hFFFF_FFFF;
            2: return 0;
            default: return $urandom_range(0, 8);
        endcase
    endfunction

    // weighted random commands
    task automatic random_phase(int n);
        int k;
        logic [1:0] c;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (k < 25) c = CMD_CREATE;
            else if (k < 55) c = CMD_TICK;
            else if (k < 80) c = CMD_SCHEDULE;
            else c = CMD_DELAY;
            send_cmd(c, ($urandom_range(0, 9) == 0) ? 8'($urandom()) :
                     8'($urandom_range(0, PTS_NUM_PRIO - 1)), pick_ms());
        end
    endtask

    initial begin
        sched_mirror = new();
        burst_left = 0;
        i_rst_n = 0;
        i_cfg_wr_en = 0;
        i_cfg_wr_data = '0;
        cmd_ch.valid = 0;
        cmd_ch.cmd = CMD_CREATE;
        cmd_ch.priority_req = '0;
        cmd_ch.delay_ms = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: errors on empty state, priority extremes, full table
        send_cmd(CMD_SCHEDULE, 8'd0, 32'd0);
        send_cmd(CMD_DELAY, 8'd0, 32'd5);
        send_cmd(CMD_CREATE, 8'd255, 32'd0);
        send_cmd(CMD_CREATE, 8'd8, 32'd0);
        send_cmd(CMD_CREATE, 8'd7, 32'hFFFF_FFFF);
        send_cmd(CMD_CREATE, 8'd0, 32'd0);
        send_cmd(CMD_SCHEDULE, 8'd0, 32'd0);
        send_cmd(CMD_DELAY, 8'd0, 32'd0);
        send_cmd(CMD_SCHEDULE, 8'd0, 32'd0);
        send_cmd(CMD_DELAY, 8'd0, 32'd1);
        send_cmd(CMD_TICK, 8'd0, 32'd0);
        send_cmd(CMD_TICK, 8'd0, 32'd0);
        for (int i = 0; i < 15; i++) send_cmd(CMD_CREATE, 8'(i % 8), 32'd0);
        send_cmd(CMD_CREATE, 8'd3, 32'd0);

        // the sender holds off until everything has come back
        drain();
        write_rate(20'd1);
        random_phase(300);
        write_rate(20'hFFFFF);
        random_phase(300);
        write_rate(20'd0);
        random_phase(150);
        write_rate(20'd1000);
        random_phase(300);
        write_rate(20'($urandom_range(1, 1000000)));
        random_phase(300);
        drain();
        repeat (100) @(negedge i_clk);
        if (sched_mirror.errors == 0 && sched_mirror.pending.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

FILE: filelist.f
src/pts_pkg.sv
src/pts_if.sv
src/priority_task_scheduler.sv
src/pts_checker.sv
test/pts_scoreboard.sv
test/testbench.sv
